// File: hw/rtl/mpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared types and constants of the pulse-width manchester frame decoder.
// ----------------------------------------------------------------------------
package mpfd_pkg;

   localparam int FRAME_BYTES = 7;
   localparam int FRAME_W     = 8 * FRAME_BYTES;
   localparam int SHIFT_W     = 64;
   localparam int DUR_W       = 16;
   localparam int PCT_W       = 7;
   localparam int PRE_W       = 8;
   localparam int BITS_W      = 7;
   localparam int CMD_W       = 4;
   localparam int ROLL_W      = 16;
   localparam int ADDR_W      = 24;
   localparam int CMD_LSB     = 40;
   localparam int ROLL_LSB    = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int PROD_W      = DUR_W + PCT_W;
   localparam int SCALED_W    = DUR_W + 8;
   localparam logic [7:0] PCT_SCALE = 8'd100;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_TIME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TIME  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PREAMBLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_BITS = 3'd4;

   // reset values
   localparam logic [DUR_W-1:0]  RST_SHORT_TIME = 16'd640;
   localparam logic [DUR_W-1:0]  RST_LONG_TIME  = 16'd1280;
   localparam logic [PCT_W-1:0]  RST_TOLERANCE  = 7'd25;
   localparam logic [PRE_W-1:0]  RST_PREAMBLE   = 8'd4;
   localparam logic [BITS_W-1:0] RST_FRAME_BITS = 7'd56;

   typedef struct packed {
      logic [DUR_W-1:0]  short_half_bit_time;
      logic [DUR_W-1:0]  long_full_bit_time;
      logic [PCT_W-1:0]  tolerance_percent;
      logic [PRE_W-1:0]  preamble_pulses;
      logic [BITS_W-1:0] frame_bits;
   } cfg_type;

   // classified pulse handed from front to back
   typedef struct packed {
      logic near_short;
      logic near_long;
      logic sync;
      logic last;
   } pulse_class_type;

endpackage

// File: hw/rtl/mpfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd interfaces
// Valid/ready channels for pulses, results and register writes.
// ----------------------------------------------------------------------------
interface mpfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [mpfd_pkg::DUR_W-1:0] duration;
   logic                       last_pulse;
   modport source (output valid, output duration, output last_pulse, input ready);
   modport sink   (input valid, input duration, input last_pulse, output ready);
endinterface

interface mpfd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [mpfd_pkg::FRAME_W-1:0] frame_value;
   logic [mpfd_pkg::CMD_W-1:0]   command;
   logic [mpfd_pkg::ROLL_W-1:0]  rolling_code;
   logic [mpfd_pkg::ADDR_W-1:0]  address;
   modport source (output valid, output ok, output frame_value, output command,
                   output rolling_code, output address, input ready);
   modport sink   (input valid, input ok, input frame_value, input command,
                   input rolling_code, input address, output ready);
endinterface

interface mpfd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mpfd_pkg::CSR_IDX_W-1:0]  index;
   logic [mpfd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mpfd_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_csr
// Configuration registers, written through the register write channel.
// ----------------------------------------------------------------------------
module mpfd_csr (
   input  logic              clock,
   input  logic              reset,
   mpfd_csr_if.sink          csr_bus,
   output mpfd_pkg::cfg_type cfg
);

   mpfd_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            mpfd_pkg::REG_SHORT_TIME: cfg_in.short_half_bit_time = csr_bus.data;
            mpfd_pkg::REG_LONG_TIME:  cfg_in.long_full_bit_time  = csr_bus.data;
            mpfd_pkg::REG_TOLERANCE:
               cfg_in.tolerance_percent = csr_bus.data[mpfd_pkg::PCT_W-1:0];
            mpfd_pkg::REG_PREAMBLE:
               cfg_in.preamble_pulses = csr_bus.data[mpfd_pkg::PRE_W-1:0];
            mpfd_pkg::REG_FRAME_BITS:
               cfg_in.frame_bits = csr_bus.data[mpfd_pkg::BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_half_bit_time <= mpfd_pkg::RST_SHORT_TIME;
         cfg_ff.long_full_bit_time  <= mpfd_pkg::RST_LONG_TIME;
         cfg_ff.tolerance_percent   <= mpfd_pkg::RST_TOLERANCE;
         cfg_ff.preamble_pulses     <= mpfd_pkg::RST_PREAMBLE;
         cfg_ff.frame_bits          <= mpfd_pkg::RST_FRAME_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/mpfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_front
// Accepts pulses and classifies them as short, long or sync against the
// configured nominal times and tolerance.
// ----------------------------------------------------------------------------
module mpfd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  mpfd_pkg::cfg_type        cfg,
   mpfd_req_if.sink                 req_bus,
   output logic                     push_valid,
   input  logic                     push_ready,
   output mpfd_pkg::pulse_class_type push_item
);

   localparam int DW = mpfd_pkg::DUR_W;
   localparam int PW = mpfd_pkg::PROD_W;
   localparam int SW = mpfd_pkg::SCALED_W;

   logic          s1_valid_ff, s1_valid_in;
   logic [DW-1:0] diff_s_ff, diff_l_ff, diff_s_in, diff_l_in;
   logic [PW-1:0] prod_s_ff, prod_l_ff, prod_s_in, prod_l_in;
   logic          sync_ff, sync_in, last_ff;
   logic          accept;
   logic [SW-1:0] scaled_s, scaled_l;
   logic [DW-1:0] d;

   assign req_bus.ready = !s1_valid_ff || push_ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign d = req_bus.duration;

   // stage one: distance from nominal, nominal times percent, sync test
   always_comb begin
      diff_s_in = (d > cfg.short_half_bit_time) ? d - cfg.short_half_bit_time
                                                : cfg.short_half_bit_time - d;
      diff_l_in = (d > cfg.long_full_bit_time) ? d - cfg.long_full_bit_time
                                               : cfg.long_full_bit_time - d;
      prod_s_in = PW'(cfg.short_half_bit_time) * PW'(cfg.tolerance_percent);
      prod_l_in = PW'(cfg.long_full_bit_time) * PW'(cfg.tolerance_percent);
      sync_in   = {1'b0, d} > {cfg.long_full_bit_time, 1'b0};
      s1_valid_in = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_ff);
   end

   // diff < floor(prod / 100)  <=>  100 * (diff + 1) <= prod
   assign scaled_s = (SW'(diff_s_ff) + SW'(1)) * SW'(mpfd_pkg::PCT_SCALE);
   assign scaled_l = (SW'(diff_l_ff) + SW'(1)) * SW'(mpfd_pkg::PCT_SCALE);

   assign push_valid           = s1_valid_ff;
   assign push_item.near_short = scaled_s <= SW'(prod_s_ff);
   assign push_item.near_long  = scaled_l <= SW'(prod_l_ff);
   assign push_item.sync       = sync_ff;
   assign push_item.last       = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_s_ff <= diff_s_in;
         diff_l_ff <= diff_l_in;
         prod_s_ff <= prod_s_in;
         prod_l_ff <= prod_l_in;
         sync_ff   <= sync_in;
         last_ff   <= req_bus.last_pulse;
      end
   end

endmodule

// File: hw/rtl/mpfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_queue
// Small first-in first-out queue of classified pulses between front and back.
// ----------------------------------------------------------------------------
module mpfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  mpfd_pkg::pulse_class_type push_item,
   output logic                      pop_valid,
   input  logic                      pop,
   output mpfd_pkg::pulse_class_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mpfd_pkg::pulse_class_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/mpfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_back
// Decoder state machine: preamble skip, sync search, manchester bit
// collection, and the result register with the descrambled frame.
// ----------------------------------------------------------------------------
module mpfd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mpfd_pkg::cfg_type         cfg,
   input  logic                      pop_valid,
   output logic                      pop,
   input  mpfd_pkg::pulse_class_type pop_item,
   mpfd_rsp_if.source                rsp_bus
);

   localparam logic [2:0] PH_PREAMBLE = 3'd0;
   localparam logic [2:0] PH_SYNC     = 3'd1;
   localparam logic [2:0] PH_DATA     = 3'd2;
   localparam logic [2:0] PH_COMPLETE = 3'd3;
   localparam logic [2:0] PH_FAILED   = 3'd4;

   localparam int FW = mpfd_pkg::FRAME_W;
   localparam int SRW = mpfd_pkg::SHIFT_W;
   localparam int BW = mpfd_pkg::BITS_W;

   logic [2:0]               phase_ff, phase_in;
   logic [mpfd_pkg::PRE_W-1:0] pre_cnt_ff, pre_cnt_in;
   logic                     half_ff, half_in;
   logic                     level_ff, level_in;
   logic [SRW-1:0]           sr_ff, sr_in;
   logic [BW-1:0]            bits_ff, bits_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     ok_ff, ok_in;
   logic [FW-1:0]            frame_ff, frame_in;

   logic                     push_bit;
   logic [FW-1:0]            raw;

   // a non-final pulse never needs the result register
   assign pop = pop_valid && (!pop_item.last || !rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      phase_in   = phase_ff;
      pre_cnt_in = pre_cnt_ff;
      half_in    = half_ff;
      level_in   = level_ff;
      push_bit   = 1'b0;

      unique case (phase_ff)
         PH_PREAMBLE: begin
            if (pre_cnt_ff < cfg.preamble_pulses) begin
               pre_cnt_in = pre_cnt_ff + mpfd_pkg::PRE_W'(1);
            end else begin
               // this pulse is already a sync candidate
               phase_in = pop_item.sync ? PH_DATA : PH_SYNC;
            end
         end
         PH_SYNC: begin
            if (pop_item.sync) begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (bits_ff >= cfg.frame_bits) begin
               phase_in = PH_COMPLETE;
            end else if (half_ff) begin
               half_in = 1'b0;
               if (pop_item.near_short) begin
                  push_bit = 1'b1;
               end else begin
                  phase_in = PH_FAILED;
               end
            end else if (pop_item.near_short) begin
               half_in = 1'b1;
            end else if (pop_item.near_long) begin
               level_in = ~level_ff;
               push_bit = 1'b1;
            end else begin
               phase_in = PH_FAILED;
            end
         end
         default: ;
      endcase

      sr_in   = push_bit ? {sr_ff[SRW-2:0], level_in} : sr_ff;
      bits_in = (push_bit && bits_ff != '1) ? bits_ff + BW'(1) : bits_ff;

      // result from the state after this pulse
      ok_in    = (phase_in != PH_FAILED) && (bits_in >= cfg.frame_bits);
      raw      = sr_in[FW-1:0];
      frame_in = ok_in ? (raw ^ (raw >> 8)) : '0;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (pop && pop_item.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PREAMBLE;
         pre_cnt_ff   <= '0;
         half_ff      <= 1'b0;
         level_ff     <= 1'b1;
         sr_ff        <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (pop_item.last) begin
               phase_ff   <= PH_PREAMBLE;
               pre_cnt_ff <= '0;
               half_ff    <= 1'b0;
               level_ff   <= 1'b1;
               sr_ff      <= '0;
               bits_ff    <= '0;
            end else begin
               phase_ff   <= phase_in;
               pre_cnt_ff <= pre_cnt_in;
               half_ff    <= half_in;
               level_ff   <= level_in;
               sr_ff      <= sr_in;
               bits_ff    <= bits_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_item.last) begin
         ok_ff    <= ok_in;
         frame_ff <= frame_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.ok           = ok_ff;
   assign rsp_bus.frame_value  = frame_ff;
   assign rsp_bus.command      = frame_ff[mpfd_pkg::CMD_LSB +: mpfd_pkg::CMD_W];
   assign rsp_bus.rolling_code = frame_ff[mpfd_pkg::ROLL_LSB +: mpfd_pkg::ROLL_W];
   assign rsp_bus.address      = frame_ff[mpfd_pkg::ADDR_W-1:0];

endmodule

// File: hw/rtl/manchester_pulse_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_pulse_frame_decoder_unit
// Pulse-width manchester frame decoder: classifier front, pulse queue and
// decoder back with a result register.
// ----------------------------------------------------------------------------
// final pulses pass the front register and queue into the result register
// throughput: one pulse per cycle while the queue is not full
// a waiting result stalls only final pulses; the queue absorbs the rest
// reset (synchronous) empties the queue, drops any pending result, restores
// register defaults and returns the decoder to preamble skipping
module manchester_pulse_frame_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   mpfd_req_if.sink   req_bus,
   mpfd_rsp_if.source rsp_bus,
   mpfd_csr_if.sink   csr_bus
);

   mpfd_pkg::cfg_type         cfg;
   logic                      push_valid, push_ready, pop_valid, pop;
   mpfd_pkg::pulse_class_type push_item, pop_item;

   mpfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mpfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   mpfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   mpfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item),
      .rsp_bus   (rsp_bus)
   );

endmodule

// File: hw/rtl/mpfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_checker
// Port-level checks of the decoder result channel.
// ----------------------------------------------------------------------------
module mpfd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_ok,
   input logic [mpfd_pkg::FRAME_W-1:0] rsp_frame_value,
   input logic [mpfd_pkg::CMD_W-1:0]   rsp_command,
   input logic [mpfd_pkg::ROLL_W-1:0]  rsp_rolling_code,
   input logic [mpfd_pkg::ADDR_W-1:0]  rsp_address
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
                                  && $stable(rsp_frame_value))
      else $error("result changed while stalled");

   // a failed capture carries an all-zero frame
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_frame_value == '0 && rsp_command == '0
                               && rsp_rolling_code == '0 && rsp_address == '0)
      else $error("failure result with nonzero fields");

   // decoded fields are slices of the frame
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_command == rsp_frame_value[mpfd_pkg::CMD_LSB +: mpfd_pkg::CMD_W]
                    && rsp_rolling_code
                       == rsp_frame_value[mpfd_pkg::ROLL_LSB +: mpfd_pkg::ROLL_W]
                    && rsp_address == rsp_frame_value[mpfd_pkg::ADDR_W-1:0])
      else $error("result fields disagree with frame");

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind manchester_pulse_frame_decoder_unit mpfd_checker u_mpfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_ok           (rsp_bus.ok),
   .rsp_frame_value  (rsp_bus.frame_value),
   .rsp_command      (rsp_bus.command),
   .rsp_rolling_code (rsp_bus.rolling_code),
   .rsp_address      (rsp_bus.address)
);
